// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the clipper RTL.
// No dependencies; compiled away when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property checked on every rising edge outside reset
`define CSP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
// condition in one cycle implies another in the next
`define CSP_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define CSP_ASSERT(label, clk, rst, prop)
`define CSP_ASSERT_NEXT(label, clk, rst, pre, post)
`endif

`endif

// ===== rtl/csp_pkg.sv =====
// Shared types, constants and helpers for the segment-to-polygon clipper.
// No dependencies.
package csp_pkg;

   localparam int MAX_VERTICES_DEF = 64;

   typedef logic signed [31:0] coord_type;
   typedef logic signed [32:0] diff_type;
   typedef logic signed [65:0] prod_type;
   typedef logic signed [66:0] cross_type;

   // x in the upper half, y in the lower half
   typedef struct packed {
      coord_type x;
      coord_type y;
   } point_type;

   typedef enum logic [1:0] {
      MODE_CLEAR  = 2'd0,
      MODE_APPEND = 2'd1,
      MODE_CLIP   = 2'd2,
      MODE_NOP    = 2'd3
   } mode_type;

   typedef struct packed {
      logic clear;
      logic valid;
   } edge_ctl_type;

   typedef struct packed {
      logic      busy;
      logic [1:0] cnt;
      logic      in_s;
      logic      in_e;
      cross_type num0;
      cross_type den0;
      cross_type num1;
      cross_type den1;
   } edge_res_type;

   function automatic diff_type diff(input coord_type a, input coord_type b);
      return $signed({a[31], a}) - $signed({b[31], b});
   endfunction

   function automatic cross_type csub(input prod_type a, input prod_type b);
      return $signed({a[65], a}) - $signed({b[65], b});
   endfunction

   // both nonzero and of equal sign
   function automatic logic one_side(input cross_type a, input cross_type b);
      return (a != '0) && (b != '0) && (a[66] == b[66]);
   endfunction

endpackage

// ===== rtl/csp_cell.sv =====
// One vertex cell of the polygon ring: holds a point, loads or passes it on.
// Depends on csp_pkg.
module csp_cell (
   input  logic                clock,
   input  logic                shift,
   input  logic                load,
   input  csp_pkg::point_type  load_pt,
   input  csp_pkg::point_type  next_pt,
   output csp_pkg::point_type  pt
);
   import csp_pkg::*;

   point_type pt_ff, pt_in;

   always_comb begin
      pt_in = pt_ff;
      if (load) begin
         pt_in = load_pt;
      end else if (shift) begin
         pt_in = next_pt;
      end
   end

   always_ff @(posedge clock) begin
      pt_ff <= pt_in;
   end

   assign pt = pt_ff;

endmodule

// ===== rtl/csp_edge.sv =====
// Edge test pipeline: differences, products, exact cross signs, then
// accumulation of crossing count, first two crossings and parity flags.
// Depends on csp_pkg.
module csp_edge (
   input  logic                   clock,
   input  logic                   reset,
   input  csp_pkg::edge_ctl_type  ctl,
   input  csp_pkg::point_type     v1,
   input  csp_pkg::point_type     v2,
   input  csp_pkg::point_type     s,
   input  csp_pkg::point_type     e,
   output csp_pkg::edge_res_type  res
);
   import csp_pkg::*;

   typedef struct packed {
      diff_type sex, sey, vx, vy, s2x, s2y, e2x, e2y;
      diff_type v1ex, v1ey, v2ex, v2ey, s1x, s1y, e1x, e1y;
      logic     span_s, span_e, vx_neg;
   } dstage_type;

   typedef struct packed {
      prod_type den_a, den_b, o1_a, o1_b, o2_a, o2_b, o3_a, o3_b;
      prod_type o4_a, o4_b, num_a, num_b, ie_a, ie_b;
      logic     span_s, span_e, vx_neg;
   } pstage_type;

   dstage_type d_ff, d_in;
   pstage_type p_ff, p_in;
   logic       v_d_ff, v_p_ff;

   logic [1:0] cnt_ff, cnt_in;
   logic       in_s_ff, in_s_in, in_e_ff, in_e_in;
   cross_type  num0_ff, num0_in, den0_ff, den0_in, num1_ff, num1_in, den1_ff, den1_in;

   cross_type  den, o1, o2, o3, o4, num, ie;
   logic       hit;

   // stage 1: coordinate differences and x-span flags
   always_comb begin
      d_in.sex  = diff(s.x, e.x);   d_in.sey  = diff(s.y, e.y);
      d_in.vx   = diff(v1.x, v2.x); d_in.vy   = diff(v1.y, v2.y);
      d_in.s2x  = diff(s.x, v2.x);  d_in.s2y  = diff(s.y, v2.y);
      d_in.e2x  = diff(e.x, v2.x);  d_in.e2y  = diff(e.y, v2.y);
      d_in.v1ex = diff(v1.x, e.x);  d_in.v1ey = diff(v1.y, e.y);
      d_in.v2ex = diff(v2.x, e.x);  d_in.v2ey = diff(v2.y, e.y);
      d_in.s1x  = diff(s.x, v1.x);  d_in.s1y  = diff(s.y, v1.y);
      d_in.e1x  = diff(e.x, v1.x);  d_in.e1y  = diff(e.y, v1.y);
      d_in.span_s = (v1.x <= s.x && s.x < v2.x) || (v2.x <= s.x && s.x < v1.x);
      d_in.span_e = (v1.x <= e.x && e.x < v2.x) || (v2.x <= e.x && e.x < v1.x);
      d_in.vx_neg = d_in.vx[32];
   end

   // stage 2: one multiplier per product term
   always_comb begin
      p_in.den_a = $signed(d_ff.sex)  * $signed(d_ff.vy);
      p_in.den_b = $signed(d_ff.vx)   * $signed(d_ff.sey);
      p_in.o1_a  = $signed(d_ff.vx)   * $signed(d_ff.s2y);
      p_in.o1_b  = $signed(d_ff.s2x)  * $signed(d_ff.vy);
      p_in.o2_a  = $signed(d_ff.vx)   * $signed(d_ff.e2y);
      p_in.o2_b  = $signed(d_ff.e2x)  * $signed(d_ff.vy);
      p_in.o3_a  = $signed(d_ff.sex)  * $signed(d_ff.v1ey);
      p_in.o3_b  = $signed(d_ff.v1ex) * $signed(d_ff.sey);
      p_in.o4_a  = $signed(d_ff.sex)  * $signed(d_ff.v2ey);
      p_in.o4_b  = $signed(d_ff.v2ex) * $signed(d_ff.sey);
      p_in.num_a = $signed(d_ff.s1x)  * $signed(d_ff.vy);
      p_in.num_b = $signed(d_ff.vx)   * $signed(d_ff.s1y);
      p_in.ie_a  = $signed(d_ff.e1x)  * $signed(d_ff.vy);
      p_in.ie_b  = $signed(d_ff.vx)   * $signed(d_ff.e1y);
      p_in.span_s = d_ff.span_s;
      p_in.span_e = d_ff.span_e;
      p_in.vx_neg = d_ff.vx_neg;
   end

   // stage 3: cross values, signs, accumulate
   always_comb begin
      den = csub(p_ff.den_a, p_ff.den_b);
      o1  = csub(p_ff.o1_a, p_ff.o1_b);
      o2  = csub(p_ff.o2_a, p_ff.o2_b);
      o3  = csub(p_ff.o3_a, p_ff.o3_b);
      o4  = csub(p_ff.o4_a, p_ff.o4_b);
      num = csub(p_ff.num_a, p_ff.num_b);
      ie  = csub(p_ff.ie_a, p_ff.ie_b);
      hit = (den != '0) && !one_side(o1, o2) && !one_side(o3, o4);

      cnt_in  = cnt_ff;
      in_s_in = in_s_ff;
      in_e_in = in_e_ff;
      num0_in = num0_ff; den0_in = den0_ff;
      num1_in = num1_ff; den1_in = den1_ff;
      if (ctl.clear) begin
         cnt_in  = '0;
         in_s_in = 1'b0;
         in_e_in = 1'b0;
      end else if (v_p_ff) begin
         if (hit) begin
            if (cnt_ff == 2'd0) begin
               num0_in = num; den0_in = den;
            end else if (cnt_ff == 2'd1) begin
               num1_in = num; den1_in = den;
            end
            if (cnt_ff != 2'd3) begin
               cnt_in = cnt_ff + 2'd1;
            end
         end
         // edge above the point when the sign disagrees with the edge direction
         if (p_ff.span_s && (p_ff.vx_neg ? num[66] : (num != '0 && !num[66]))) begin
            in_s_in = !in_s_ff;
         end
         if (p_ff.span_e && (p_ff.vx_neg ? ie[66] : (ie != '0 && !ie[66]))) begin
            in_e_in = !in_e_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_d_ff  <= 1'b0;
         v_p_ff  <= 1'b0;
         cnt_ff  <= '0;
         in_s_ff <= 1'b0;
         in_e_ff <= 1'b0;
      end else begin
         v_d_ff  <= ctl.valid;
         v_p_ff  <= v_d_ff;
         cnt_ff  <= cnt_in;
         in_s_ff <= in_s_in;
         in_e_ff <= in_e_in;
      end
   end

   always_ff @(posedge clock) begin
      d_ff    <= d_in;
      p_ff    <= p_in;
      num0_ff <= num0_in; den0_ff <= den0_in;
      num1_ff <= num1_in; den1_ff <= den1_in;
   end

   always_comb begin
      res.busy = v_d_ff || v_p_ff;
      res.cnt  = cnt_ff;
      res.in_s = in_s_ff;
      res.in_e = in_e_ff;
      res.num0 = num0_ff; res.den0 = den0_ff;
      res.num1 = num1_ff; res.den1 = den1_ff;
   end

endmodule

// ===== rtl/csp_lerp.sv =====
// Crossing coordinate unit: base + round(delta * num / den), ties away
// from zero, by a serial shift-add multiply then a restoring divide.
// Depends on csp_pkg.
module csp_lerp (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  csp_pkg::coord_type  base,
   input  csp_pkg::diff_type   delta,
   input  csp_pkg::cross_type  num,
   input  csp_pkg::cross_type  den,
   output logic                busy,
   output logic                done,
   output csp_pkg::coord_type  result
);
   import csp_pkg::*;

   typedef enum logic [3:0] {
      L_IDLE = 4'b0001,
      L_MUL  = 4'b0010,
      L_DIV  = 4'b0100,
      L_FIN  = 4'b1000
   } lstate_type;

   localparam logic [5:0] LAST_STEP = 6'd33;

   lstate_type  st_ff, st_in;
   logic [5:0]  step_ff, step_in;
   logic        neg_ff, neg_in;
   logic [65:0] nm_ff, nm_in, dm_ff, dm_in;
   logic [32:0] ud_ff, ud_in;
   coord_type   base_ff, base_in;
   logic [99:0] acc_ff, acc_in, addend;
   logic [67:0] rem_ff, rem_in, trial, bot;
   logic [33:0] q_ff, q_in;
   cross_type   num_abs, den_abs;
   diff_type    delta_abs;

   always_comb begin
      num_abs   = num[66] ? -num : num;
      den_abs   = den[66] ? -den : den;
      delta_abs = delta[32] ? -delta : delta;
      bot       = {1'b0, dm_ff, 1'b0};
      trial     = {rem_ff[66:0], acc_ff[33]};
      addend    = (step_ff == LAST_STEP) ? 100'(dm_ff) :
                  (ud_ff[32] ? 100'(nm_ff) : '0);

      st_in   = st_ff;
      step_in = step_ff;
      neg_in  = neg_ff;
      nm_in   = nm_ff;
      dm_in   = dm_ff;
      ud_in   = ud_ff;
      base_in = base_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;

      unique case (st_ff)
         L_IDLE: begin
            if (start) begin
               neg_in  = delta[32] ^ num[66] ^ den[66];
               nm_in   = num_abs[65:0];
               dm_in   = den_abs[65:0];
               ud_in   = delta_abs;
               base_in = base;
               acc_in  = '0;
               step_in = '0;
               st_in   = L_MUL;
            end
         end
         L_MUL: begin
            // 33 multiply steps, then one more that forms 2P + den
            acc_in  = {acc_ff[98:0], 1'b0} + addend;
            ud_in   = {ud_ff[31:0], 1'b0};
            step_in = step_ff + 6'd1;
            if (step_ff == LAST_STEP) begin
               rem_in  = 68'(acc_in[99:34]);
               step_in = '0;
               st_in   = L_DIV;
            end
         end
         L_DIV: begin
            if (trial >= bot) begin
               rem_in = trial - bot;
               q_in   = {q_ff[32:0], 1'b1};
            end else begin
               rem_in = trial;
               q_in   = {q_ff[32:0], 1'b0};
            end
            acc_in  = {acc_ff[98:0], 1'b0};
            step_in = step_ff + 6'd1;
            if (step_ff == LAST_STEP) begin
               st_in = L_FIN;
            end
         end
         L_FIN: begin
            st_in = L_IDLE;
         end
         default: begin
            st_in = L_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= L_IDLE;
         step_ff <= '0;
      end else begin
         st_ff   <= st_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff  <= neg_in;
      nm_ff   <= nm_in;
      dm_ff   <= dm_in;
      ud_ff   <= ud_in;
      base_ff <= base_in;
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
   end

   assign busy   = (st_ff != L_IDLE);
   assign done   = (st_ff == L_FIN);
   assign result = neg_ff ? base_ff - $signed(q_ff[31:0]) : base_ff + $signed(q_ff[31:0]);

endmodule

// ===== rtl/clip_segment_to_polygon.sv =====
// Clip request: a walk of the vertex ring, a drain of the edge pipeline, each
// crossing coordinate in turn in the shared multiply/divide unit (two per
// crossing, at most four), a distance compare when there are two crossings,
// then one response per piece to emit. Clear, append and no-op requests are
// handled in the idle state. Synchronous active-high reset empties the polygon
// and idles control.
`include "assert_macros.svh"

module clip_segment_to_polygon #(
   parameter int MAX_VERTICES = csp_pkg::MAX_VERTICES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // start_x, start_y, end_x, end_y (32 bits each)
   input  logic [1:0]   req_tuser,   // mode
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,   // out_start_x, out_start_y, out_end_x, out_end_y
   output logic         rsp_tlast    // last piece of this segment
);
   import csp_pkg::*;

   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam logic [CW-1:0] NV = CW'(MAX_VERTICES);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_WALK  = 6'b000010,
      ST_DRAIN = 6'b000100,
      ST_LERP  = 6'b001000,
      ST_NEAR  = 6'b010000,
      ST_EMIT  = 6'b100000
   } state_type;

   typedef struct packed {
      point_type a;
      point_type b;
   } piece_type;

   state_type   state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;   // vertices held
   logic [CW-1:0] walk_ff, walk_in;     // ring position during the walk
   point_type   s_ff, s_in, e_ff, e_in;
   point_type   first_ff, first_in, prev_ff, prev_in;
   logic [1:0]  job_ff, job_in, jobs;
   logic        lerp_start_ff, lerp_start_in;
   logic        pc_ff, pc_in;           // piece being emitted
   coord_type   hx_ff [2];
   coord_type   hy_ff [2];
   logic [64:0] sq_ff [8];
   logic [64:0] sq_in [8];
   diff_type    dd [8];

   logic        rsp_valid_ff, rsp_valid_in;
   piece_type   rsp_piece_ff, rsp_piece_in;
   logic        rsp_last_ff, rsp_last_in;

   logic        req_go, append_go;
   mode_type    mode;
   point_type   req_s, req_e;

   point_type   ring [MAX_VERTICES];
   point_type   head;
   logic        ring_shift;

   edge_ctl_type edge_ctl;
   edge_res_type edge_res;
   point_type    edge_v2;

   logic        lerp_busy, lerp_done;
   coord_type   lerp_base, lerp_result;
   diff_type    lerp_delta;
   cross_type   lerp_num, lerp_den;

   point_type   h0, h1, near_s, near_e;
   logic [65:0] ds0, ds1, de0, de1;
   piece_type   p0, p1;
   logic [1:0]  np;
   logic        slot_free;

   // request unpacking
   assign mode      = mode_type'(req_tuser);
   assign req_s     = '{x: req_tdata[31:0], y: req_tdata[63:32]};
   assign req_e     = '{x: req_tdata[95:64], y: req_tdata[127:96]};
   assign req_tready = (state_ff == ST_IDLE);
   assign req_go    = req_tvalid && req_tready;
   assign append_go = req_go && (mode == MODE_APPEND) && (count_ff < NV);

   // vertex ring: cell k holds vertex k at rest; a walk rotates it once
   assign ring_shift = (state_ff == ST_WALK) && (walk_ff < NV);
   assign head       = ring[0];

   for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_ring
      csp_cell u_cell (
         .clock   (clock),
         .shift   (ring_shift),
         .load    (append_go && (count_ff == CW'(k))),
         .load_pt (req_s),
         .next_pt (ring[(k + 1) % MAX_VERTICES]),
         .pt      (ring[k])
      );
   end

   // edge i runs from vertex i to vertex i+1; the closing edge uses the
   // first vertex kept at the start of the walk
   always_comb begin
      edge_ctl.clear = req_go && (mode == MODE_CLIP);
      edge_ctl.valid = (state_ff == ST_WALK) &&
                       (((walk_ff != '0) && (walk_ff < count_ff)) ||
                        ((walk_ff == count_ff) && (count_ff != '0)));
      edge_v2 = (walk_ff == count_ff) ? first_ff : head;
   end

   csp_edge u_edge (
      .clock (clock),
      .reset (reset),
      .ctl   (edge_ctl),
      .v1    (prev_ff),
      .v2    (edge_v2),
      .s     (s_ff),
      .e     (e_ff),
      .res   (edge_res)
   );

   // job bit 1 picks the crossing, bit 0 the coordinate
   always_comb begin
      lerp_base  = job_ff[0] ? s_ff.y : s_ff.x;
      lerp_delta = job_ff[0] ? diff(e_ff.y, s_ff.y) : diff(e_ff.x, s_ff.x);
      lerp_num   = job_ff[1] ? edge_res.num1 : edge_res.num0;
      lerp_den   = job_ff[1] ? edge_res.den1 : edge_res.den0;
      jobs       = (edge_res.cnt == 2'd1) ? 2'd1 : 2'd3;   // index of last job
   end

   csp_lerp u_lerp (
      .clock  (clock),
      .reset  (reset),
      .start  (lerp_start_ff),
      .base   (lerp_base),
      .delta  (lerp_delta),
      .num    (lerp_num),
      .den    (lerp_den),
      .busy   (lerp_busy),
      .done   (lerp_done),
      .result (lerp_result)
   );

   // squared distances from S and E to both crossings
   always_comb begin
      h0 = '{x: hx_ff[0], y: hy_ff[0]};
      h1 = '{x: hx_ff[1], y: hy_ff[1]};
      dd[0] = diff(h0.x, s_ff.x); dd[1] = diff(h0.y, s_ff.y);
      dd[2] = diff(h1.x, s_ff.x); dd[3] = diff(h1.y, s_ff.y);
      dd[4] = diff(h0.x, e_ff.x); dd[5] = diff(h0.y, e_ff.y);
      dd[6] = diff(h1.x, e_ff.x); dd[7] = diff(h1.y, e_ff.y);
      for (int i = 0; i < 8; i++) begin
         sq_in[i] = 65'($signed(dd[i]) * $signed(dd[i]));
      end
      ds0 = {1'b0, sq_ff[0]} + {1'b0, sq_ff[1]};
      ds1 = {1'b0, sq_ff[2]} + {1'b0, sq_ff[3]};
      de0 = {1'b0, sq_ff[4]} + {1'b0, sq_ff[5]};
      de1 = {1'b0, sq_ff[6]} + {1'b0, sq_ff[7]};
      // a tie goes to the second crossing
      near_s = (ds0 < ds1) ? h0 : h1;
      near_e = (de0 < de1) ? h0 : h1;
   end

   // piece table by crossing count and inside flags of S and E
   always_comb begin
      np = 2'd0;
      p0 = '{a: s_ff, b: e_ff};
      p1 = '{a: near_e, b: e_ff};
      case (edge_res.cnt)
         2'd0: begin
            if (edge_res.in_s || edge_res.in_e) begin
               np = 2'd1;
            end
         end
         2'd1: begin
            if (edge_res.in_s && !edge_res.in_e) begin
               np = 2'd1; p0 = '{a: s_ff, b: h0};
            end else if (!edge_res.in_s && edge_res.in_e) begin
               np = 2'd1; p0 = '{a: h0, b: e_ff};
            end else if (edge_res.in_s && edge_res.in_e) begin
               np = 2'd1;
            end
         end
         2'd2: begin
            np = 2'd1;
            if (!edge_res.in_s && !edge_res.in_e) begin
               p0 = '{a: h0, b: h1};
            end else if (edge_res.in_s && !edge_res.in_e) begin
               p0 = '{a: s_ff, b: near_s};
            end else if (!edge_res.in_s && edge_res.in_e) begin
               p0 = '{a: e_ff, b: near_e};
            end else begin
               np = 2'd2;
               p0 = '{a: s_ff, b: near_s};
            end
         end
         default: begin
            np = 2'd0;   // more than two crossings
         end
      endcase
   end

   assign slot_free = !rsp_valid_ff || rsp_tready;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      walk_in       = walk_ff;
      s_in          = s_ff;
      e_in          = e_ff;
      first_in      = first_ff;
      prev_in       = prev_ff;
      job_in        = job_ff;
      lerp_start_in = 1'b0;
      pc_in         = pc_ff;
      rsp_piece_in  = rsp_piece_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_go) begin
               case (mode)
                  MODE_CLEAR: count_in = '0;
                  MODE_APPEND: begin
                     if (append_go) begin
                        count_in = count_ff + CW'(1);
                     end
                  end
                  MODE_CLIP: begin
                     s_in     = req_s;
                     e_in     = req_e;
                     walk_in  = '0;
                     state_in = ST_WALK;
                  end
                  default: ;
               endcase
            end
         end
         ST_WALK: begin
            if (walk_ff == '0) begin
               first_in = head;
            end
            if (ring_shift) begin
               prev_in = head;
               walk_in = walk_ff + CW'(1);
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!edge_res.busy) begin
               job_in = '0;
               if (edge_res.cnt == 2'd1 || edge_res.cnt == 2'd2) begin
                  lerp_start_in = 1'b1;
                  state_in      = ST_LERP;
               end else begin
                  pc_in    = 1'b0;
                  state_in = ST_EMIT;
               end
            end
         end
         ST_LERP: begin
            if (lerp_done) begin
               if (job_ff == jobs) begin
                  pc_in    = 1'b0;
                  state_in = (edge_res.cnt == 2'd2) ? ST_NEAR : ST_EMIT;
               end else begin
                  job_in        = job_ff + 2'd1;
                  lerp_start_in = 1'b1;
               end
            end
         end
         ST_NEAR: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (np == 2'd0) begin
               state_in = ST_IDLE;
            end else if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_piece_in = pc_ff ? p1 : p0;
               rsp_last_in  = (pc_ff == 1'b1) || (np == 2'd1);
               if (rsp_last_in) begin
                  state_in = ST_IDLE;
               end else begin
                  pc_in = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         walk_ff       <= '0;
         job_ff        <= '0;
         lerp_start_ff <= 1'b0;
         pc_ff         <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         walk_ff       <= walk_in;
         job_ff        <= job_in;
         lerp_start_ff <= lerp_start_in;
         pc_ff         <= pc_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s_ff         <= s_in;
      e_ff         <= e_in;
      first_ff     <= first_in;
      prev_ff      <= prev_in;
      rsp_piece_ff <= rsp_piece_in;
      rsp_last_ff  <= rsp_last_in;
      if (state_ff == ST_LERP && lerp_done) begin
         if (job_ff[0]) begin
            hy_ff[job_ff[1]] <= lerp_result;
         end else begin
            hx_ff[job_ff[1]] <= lerp_result;
         end
      end
      if (state_ff == ST_NEAR) begin
         for (int i = 0; i < 8; i++) begin
            sq_ff[i] <= sq_in[i];
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {rsp_piece_ff.b.y, rsp_piece_ff.b.x,
                        rsp_piece_ff.a.y, rsp_piece_ff.a.x};

   `CSP_ASSERT(a_accept_quiet, clock, reset, (req_tvalid && req_tready) |-> (!edge_res.busy && !lerp_busy))
   `CSP_ASSERT_NEXT(a_walk_end, clock, reset, (state_ff == ST_WALK && walk_ff == NV), (state_ff == ST_DRAIN))
   `CSP_ASSERT(a_lerp_free, clock, reset, lerp_start_ff |-> !lerp_busy)

endmodule

// ===== tb/clip_segment_to_polygon_tb.sv =====
// Self-checking bench for the segment-to-polygon clipper: directed table, a full-store check, then random traffic.
// Depends on csp_pkg and clip_segment_to_polygon; carries its own exact predictor.
module clip_segment_to_polygon_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import csp_pkg::*;

   localparam int  NVERT       = 64;
   localparam int  RANDOM_REQS = 1000;
   localparam int  DRAIN_WAIT  = 600;      // beyond one full clip at 64 vertices
   localparam longint CYCLE_LIMIT = 3_000_000;

   // 128-bit signed working width: every product and quotient fits exactly
   typedef logic signed [127:0] wide_type;
   typedef struct { wide_type x, y; } wpt_type;

   typedef struct packed {
      coord_type sx, sy, ex, ey;
      logic      last;
   } exp_piece_type;

   typedef struct {
      mode_type      mode;
      coord_type     sx, sy, ex, ey;
      bit            typed;      // expectation written into the row
      int            n_typed;    // 0 or 1 pieces
      exp_piece_type piece;
   } row_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [127:0] req_tdata;   // start_x, start_y, end_x, end_y (32 bits each)
   logic [1:0]   req_tuser;   // mode
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [127:0] rsp_tdata;   // out_start_x, out_start_y, out_end_x, out_end_y
   logic         rsp_tlast;   // last piece of this segment

   clip_segment_to_polygon u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // shadow polygon, updated as each request is accepted
   coord_type poly_x [NVERT];
   coord_type poly_y [NVERT];
   int        poly_n;

   exp_piece_type pending_pieces [$];
   int        errors;
   int        pieces_checked;
   int        reqs_sent;
   int        clips_sent;
   longint    cycles;

   // idling percentages, changed per phase
   int        send_idle_pct;
   int        recv_stall_pct;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d pieces outstanding",
                  cycles, pending_pieces.size());
         $display("Verification failed");
         $finish;
      end
   end

   task automatic report(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
   endtask

   // ---------------------------------------------------------------------------
   // Exact predictor
   // ---------------------------------------------------------------------------
   function automatic int sgn(input wide_type v);
      return v < 0 ? -1 : (v != 0 ? 1 : 0);
   endfunction

   // ax*by - bx*ay
   function automatic wide_type xprod(input wide_type ax, input wide_type ay,
                                      input wide_type bx, input wide_type by);
      return ax * by - bx * ay;
   endfunction

   function automatic int turn(input wpt_type p1, input wpt_type p2, input wpt_type p0);
      return sgn(xprod(p1.x - p0.x, p1.y - p0.y, p2.x - p0.x, p2.y - p0.y));
   endfunction

   // both ends of p strictly on one side of line l
   function automatic bit one_sided(input wpt_type p1, input wpt_type p2,
                                    input wpt_type l1, input wpt_type l2);
      return turn(l1, p1, l2) * turn(l1, p2, l2) > 0;
   endfunction

   function automatic wpt_type vert(input int i);
      wpt_type p;
      p.x = poly_x[i];
      p.y = poly_y[i];
      return p;
   endfunction

   // base + delta*num/den, rounded to nearest, ties away from zero
   function automatic wide_type interp(input wide_type base, input wide_type delta,
                                       input wide_type num, input wide_type den);
      bit       neg;
      wide_type q;
      neg = delta < 0;
      if (delta < 0) delta = -delta;
      if (num < 0) begin num = -num; neg = !neg; end
      if (den < 0) begin den = -den; neg = !neg; end
      q = (2 * num * delta + den) / (2 * den);
      return neg ? base - q : base + q;
   endfunction

   // even-odd vertical ray test
   function automatic bit inside_poly(input wpt_type a);
      bit       odd;
      wpt_type  vi, vj;
      wide_type dx;
      int       s;
      odd = 1'b0;
      for (int i = 0; i < poly_n; i++) begin
         vi = vert(i);
         vj = vert((i + 1) % poly_n);
         if ((vi.x <= a.x && a.x < vj.x) || (vj.x <= a.x && a.x < vi.x)) begin
            dx = vj.x - vi.x;
            s  = sgn((a.y - vi.y) * dx - (vj.y - vi.y) * (a.x - vi.x));
            if (dx > 0 ? s < 0 : s > 0) odd = !odd;
         end
      end
      return odd;
   endfunction

   function automatic wide_type sqdist(input wpt_type a, input wpt_type b);
      return (a.x - b.x) * (a.x - b.x) + (a.y - b.y) * (a.y - b.y);
   endfunction

   // crossing nearer to a; a tie picks c (the second crossing)
   function automatic wpt_type nearer(input wpt_type a, input wpt_type b, input wpt_type c);
      return (sqdist(a, b) < sqdist(a, c)) ? b : c;
   endfunction

   function automatic void push_piece(input wpt_type p, input wpt_type q, input logic last);
      exp_piece_type pc;
      pc.sx = p.x[31:0];
      pc.sy = p.y[31:0];
      pc.ex = q.x[31:0];
      pc.ey = q.y[31:0];
      pc.last = last;
      pending_pieces = {pending_pieces, pc};
   endfunction

   function automatic void predict_clip(input coord_type sx, input coord_type sy,
                                        input coord_type ex, input coord_type ey);
      wpt_type  s, e, v1, v2;
      wpt_type  hit [2];
      wide_type den, num;
      int       cnt;
      bit       a, b;
      s.x = sx; s.y = sy; e.x = ex; e.y = ey;
      cnt = 0;
      for (int i = 0; i < poly_n; i++) begin
         v1  = vert(i);
         v2  = vert((i + 1) % poly_n);
         den = xprod(s.x - e.x, s.y - e.y, v1.x - v2.x, v1.y - v2.y);
         if (den == 0) continue;
         if (one_sided(s, e, v1, v2) || one_sided(v1, v2, s, e)) continue;
         if (cnt < 2) begin
            num = xprod(s.x - v1.x, s.y - v1.y, v1.x - v2.x, v1.y - v2.y);
            hit[cnt].x = interp(s.x, e.x - s.x, num, den);
            hit[cnt].y = interp(s.y, e.y - s.y, num, den);
         end
         if (cnt < 3) cnt++;
      end
      a = inside_poly(s);
      b = inside_poly(e);
      case (cnt)
         0: if (a || b) push_piece(s, e, 1'b1);
         1: begin
            if (a && !b)      push_piece(s, hit[0], 1'b1);
            else if (!a && b) push_piece(hit[0], e, 1'b1);
            else if (a && b)  push_piece(s, e, 1'b1);
         end
         2: begin
            if (!a && !b)     push_piece(hit[0], hit[1], 1'b1);
            else if (a && !b) push_piece(s, nearer(s, hit[0], hit[1]), 1'b1);
            else if (!a && b) push_piece(e, nearer(e, hit[0], hit[1]), 1'b1);
            else begin
               push_piece(s, nearer(s, hit[0], hit[1]), 1'b0);
               push_piece(nearer(e, hit[0], hit[1]), e, 1'b1);
            end
         end
         default: ;   // more than two crossings: nothing
      endcase
   endfunction

   // state update and expectations for one accepted request
   function automatic void apply_request(input row_type r);
      case (r.mode)
         MODE_CLEAR:  poly_n = 0;
         MODE_APPEND: if (poly_n < NVERT) begin   // store full: dropped
            poly_x[poly_n] = r.sx;
            poly_y[poly_n] = r.sy;
            poly_n++;
         end
         MODE_CLIP: begin
            clips_sent++;
            if (r.typed) begin
               if (r.n_typed > 0) pending_pieces = {pending_pieces, r.piece};
            end else begin
               predict_clip(r.sx, r.sy, r.ex, r.ey);
            end
         end
         default: ;   // no-op
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------------
   // valid stays high across back-to-back requests; it only drops on an idle cycle
   task automatic send(input row_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.mode;
      req_tdata  <= {r.ey, r.ex, r.sy, r.sx};
      do @(posedge clock); while (!req_tready);
      apply_request(r);
      reqs_sent++;
   endtask

   function automatic row_type mk(input mode_type m, input coord_type sx, input coord_type sy,
                                  input coord_type ex, input coord_type ey);
      row_type r;
      r.mode = m;
      r.sx = sx; r.sy = sy; r.ex = ex; r.ey = ey;
      r.typed = 1'b0;
      r.n_typed = 0;
      r.piece = '0;
      return r;
   endfunction

   function automatic row_type mk_typed(input row_type r, input int n,
                                        input exp_piece_type p);
      r.typed = 1'b1;
      r.n_typed = n;
      r.piece = p;
      return r;
   endfunction

   function automatic coord_type q16(input int v);
      return coord_type'(v <<< 16);
   endfunction

   // mixture of small grid points (degenerate cases, ties), mid-range and full-range values
   function automatic coord_type rnd_coord();
      int k;
      k = $urandom_range(99);
      if (k < 50)      return q16($urandom_range(16) - 8);
      else if (k < 80) return coord_type'($urandom_range(2000 << 16) - (1000 << 16));
      else             return coord_type'($urandom);
   endfunction

   function automatic row_type rnd_row(input mode_type m);
      return mk(m, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
   endfunction

   // ---------------------------------------------------------------------------
   // Result side: check at the edge, then pick the next ready
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      exp_piece_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_pieces.size() == 0) begin
            report($sformatf("unexpected piece %h last %b", rsp_tdata, rsp_tlast));
         end else begin
            want = pending_pieces.pop_front();
            if (rsp_tdata[31:0] !== want.sx)
               report($sformatf("out_start_x %h want %h", rsp_tdata[31:0], want.sx));
            if (rsp_tdata[63:32] !== want.sy)
               report($sformatf("out_start_y %h want %h", rsp_tdata[63:32], want.sy));
            if (rsp_tdata[95:64] !== want.ex)
               report($sformatf("out_end_x %h want %h", rsp_tdata[95:64], want.ex));
            if (rsp_tdata[127:96] !== want.ey)
               report($sformatf("out_end_y %h want %h", rsp_tdata[127:96], want.ey));
            if (rsp_tlast !== want.last)
               report($sformatf("last %b want %b", rsp_tlast, want.last));
            pieces_checked++;
         end
      end
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   initial begin
      row_type       table_rows [$];
      row_type       r;
      exp_piece_type p;
      int            nv, nclip, kind;
      int            rnd_done;

      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = MODE_NOP;
      rsp_tready     = 1'b0;
      cycles         = 0;
      errors         = 0;
      pieces_checked = 0;
      reqs_sent      = 0;
      clips_sent     = 0;
      poly_n         = 0;
      send_idle_pct  = 19;
      recv_stall_pct = 55;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed table: empty, one-vertex and two-vertex polygons, a square, extremes
      table_rows = {table_rows,
                    mk_typed(mk(MODE_CLIP, q16(-3), q16(0), q16(3), q16(0)), 0, '0)};
      table_rows = {table_rows, mk(MODE_APPEND, q16(-10), q16(-10), '0, '0)};
      table_rows = {table_rows, mk(MODE_CLIP, q16(-20), q16(-10), q16(20), q16(-10))};
      table_rows = {table_rows, mk(MODE_APPEND, q16(10), q16(-10), '0, '0)};
      table_rows = {table_rows, mk(MODE_CLIP, q16(0), q16(-20), q16(0), q16(20))};
      table_rows = {table_rows, mk(MODE_APPEND, q16(10), q16(10), '0, '0)};
      table_rows = {table_rows, mk(MODE_APPEND, q16(-10), q16(10), '0, '0)};
      // wholly inside the square: passed through untouched
      p = {q16(1), q16(2), q16(3), q16(4), 1'b1};
      table_rows = {table_rows,
                    mk_typed(mk(MODE_CLIP, q16(1), q16(2), q16(3), q16(4)), 1, p)};
      table_rows = {table_rows, mk(MODE_CLIP, q16(-20), q16(0), q16(20), q16(0))};
      table_rows = {table_rows, mk(MODE_CLIP, q16(0), q16(0), q16(20), q16(5))};
      table_rows = {table_rows, mk(MODE_CLIP, q16(-20), q16(3), q16(0), q16(1))};
      table_rows = {table_rows, mk(MODE_CLIP, q16(-20), q16(-20), q16(20), q16(20))};
      table_rows = {table_rows, mk(MODE_CLIP, q16(-10), q16(-10), q16(10), q16(-10))};
      // wholly outside: nothing
      table_rows = {table_rows,
                    mk_typed(mk(MODE_CLIP, q16(30), q16(30), q16(40), q16(40)), 0, '0)};
      // unused mode with all data bits high: ignored
      table_rows = {table_rows, mk(MODE_NOP, '1, '1, '1, '1)};
      table_rows = {table_rows, mk(MODE_CLEAR, '0, '0, '0, '0)};
      table_rows = {table_rows, mk(MODE_APPEND, 32'sh8000_0000, 32'sh8000_0000, '0, '0)};
      table_rows = {table_rows, mk(MODE_APPEND, 32'sh7fff_ffff, 32'sh8000_0000, '0, '0)};
      table_rows = {table_rows, mk(MODE_APPEND, 32'sh0000_0000, 32'sh7fff_ffff, '0, '0)};
      table_rows = {table_rows, mk(MODE_CLIP, 32'sh8000_0000, 32'sh7fff_ffff,
                                   32'sh7fff_ffff, 32'sh8000_0000)};
      table_rows = {table_rows, mk(MODE_CLIP, 32'sh7fff_ffff, 32'sh7fff_ffff,
                                   32'sh8000_0000, 32'sh8000_0000)};
      table_rows = {table_rows, mk(MODE_CLIP, '0, '0, '0, '0)};
      table_rows = {table_rows, mk(MODE_CLEAR, '1, '1, '1, '1)};
      table_rows = {table_rows,
                    mk_typed(mk(MODE_CLIP, q16(-3), q16(0), q16(3), q16(0)), 0, '0)};
      foreach (table_rows[i]) send(table_rows[i]);

      // store full: two appends past capacity are dropped
      for (int i = 0; i < NVERT + 2; i++) send(rnd_row(MODE_APPEND));
      send(rnd_row(MODE_CLIP));
      send(rnd_row(MODE_CLIP));

      // random traffic: mostly clear / build small polygon / several clips
      rnd_done = 0;
      while (rnd_done < RANDOM_REQS) begin
         if (rnd_done >= 2 * RANDOM_REQS / 3) begin
            send_idle_pct = 0;  recv_stall_pct = 0;
         end else if (rnd_done >= RANDOM_REQS / 3) begin
            send_idle_pct = 55; recv_stall_pct = 19;
         end
         kind = $urandom_range(99);
         if (kind < 85) begin
            send(rnd_row(MODE_CLEAR));
            nv = ($urandom_range(19) == 0) ? $urandom_range(NVERT + 2) : $urandom_range(8);
            for (int i = 0; i < nv; i++) send(rnd_row(MODE_APPEND));
            nclip = $urandom_range(8, 1);
            for (int i = 0; i < nclip; i++) send(rnd_row(MODE_CLIP));
            rnd_done += 1 + nv + nclip;
         end else if (kind < 92) begin
            // broken sequence: stray appends and clips on the current polygon
            send(rnd_row($urandom_range(1) ? MODE_APPEND : MODE_CLIP));
            rnd_done++;
         end else begin
            send(rnd_row(MODE_NOP));
            rnd_done++;
         end
      end
      req_tvalid <= 1'b0;

      // drain: every expected piece back, then wait on to catch any unexpected piece
      while (pending_pieces.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("%0d requests sent (%0d clips), %0d clipped pieces compared, %0d errors",
               reqs_sent, clips_sent, pieces_checked, errors);
      $display("covered empty, tiny, square, extreme-range and full-store polygons");
      if (errors == 0 && pending_pieces.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
